// ===== rtl/stream_delimiter_search_macros.svh =====
// Assertion macros shared by the delimiter search checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef STREAM_DELIMITER_SEARCH_MACROS_SVH
`define STREAM_DELIMITER_SEARCH_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SDS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sds_pkg.sv =====
// Shared types, constants and helpers for the stream delimiter search.
// No dependencies; used by every module of the block.
package sds_pkg;

  localparam int BYTE_W                 = 8;
  localparam int PATTERN_BYTES          = 16;
  localparam int PATTERN_W              = PATTERN_BYTES * BYTE_W;
  localparam int BYTE_SEL_W             = $clog2(PATTERN_BYTES);
  localparam int SEP_IDX_W              = 7;
  localparam int COUNT_W                = 25;
  localparam int PLEN_W                 = 5;
  localparam int CFG_DATA_W             = 64;
  localparam int CFG_INDEX_W            = 2;
  localparam int MAX_PATTERN_DEFAULT    = 16;
  localparam int POSITION_LIMIT_DEFAULT = 16 * 1024 * 1024;
  // Power of two, so queue pointers wrap on their own.
  localparam int QUEUE_DEPTH            = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } item_t;

  typedef struct packed {
    logic               match_found;
    logic [COUNT_W-1:0] match_end;
    logic               exhausted;
  } result_t;

  // Queue entry: the request plus the front's compare of its byte
  // against the final separator byte.
  typedef struct packed {
    item_t item;
    logic  tail_eq;
  } qent_t;

  // Separator byte idx; bytes past the register pair read as zero.
  function automatic logic [BYTE_W-1:0] sep_byte(input logic [PATTERN_W-1:0] pattern,
                                                 input logic [SEP_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    b = pattern[{idx[BYTE_SEL_W-1:0], 3'b000} +: BYTE_W];
    if (idx >= SEP_IDX_W'(PATTERN_BYTES)) begin
      b = '0;
    end
    return b;
  endfunction

endpackage

// ===== rtl/sds_front.sv =====
// Front stage of the delimiter search: takes requests and classifies the byte.
// Depends on sds_pkg.
module sds_front
  import sds_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
  localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  input  logic [PATTERN_W-1:0] pattern,
  input  logic [LEN_W-1:0]     act_len,
  output logic                 push_valid,
  input  logic                 push_full,
  output qent_t                push_entry
);

  logic  front_valid;
  qent_t entry;
  logic  tail_eq;

  // Last separator byte is the one that must line up with the new byte.
  assign tail_eq = item.data_byte ==
                   sep_byte(pattern, SEP_IDX_W'(act_len) - SEP_IDX_W'(1));

  assign item_stall = front_valid && push_full;
  assign push_valid = front_valid;
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (!item_stall) begin
      front_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      entry.item    <= item;
      entry.tail_eq <= tail_eq;
    end
  end

endmodule

// ===== rtl/sds_queue.sv =====
// Short FIFO that decouples the front and back stages of the delimiter search.
// Depends on sds_pkg.
module sds_queue
  import sds_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_full,
  input  qent_t push_entry,
  output logic  pop_valid,
  input  logic  pop_ready,
  output qent_t pop_entry
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qent_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign push_full = fill == CNT_W'(QUEUE_DEPTH);
  assign pop_valid = fill != '0;
  assign pop_entry = slots[rd_ptr];
  assign push      = push_valid && !push_full;
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/sds_back.sv =====
// Back stage of the delimiter search: window compare, byte count, result register.
// Depends on sds_pkg.
module sds_back
  import sds_pkg::*;
#(
  parameter int MAX_PATTERN    = MAX_PATTERN_DEFAULT,
  parameter int POSITION_LIMIT = POSITION_LIMIT_DEFAULT,
  localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [PATTERN_W-1:0] pattern,
  input  logic [LEN_W-1:0]     act_len,
  input  logic                 head_valid,
  output logic                 head_ready,
  input  qent_t                head_entry,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result
);

  // Earlier bytes needed besides the current one.
  localparam int WIN = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

  logic [BYTE_W-1:0]  recent [WIN];
  logic [COUNT_W-1:0] bytes_seen;
  logic [COUNT_W-1:0] count_inc;
  logic               enough;
  logic               win_ok;
  logic               hit;
  logic               take;

  assign head_ready = !result_valid || !result_stall;
  assign take       = head_valid && head_ready;

  assign count_inc = (bytes_seen < COUNT_W'(POSITION_LIMIT)) ? bytes_seen + COUNT_W'(1)
                                                             : bytes_seen;
  assign enough    = count_inc >= COUNT_W'(act_len);

  // recent[k] must equal separator byte len-2-k for every k below len-1.
  always_comb begin
    win_ok = 1'b1;
    for (int k = 0; k < WIN; k++) begin
      if (SEP_IDX_W'(k + 1) < SEP_IDX_W'(act_len) &&
          recent[k] != sep_byte(pattern, SEP_IDX_W'(act_len) - SEP_IDX_W'(k + 2))) begin
        win_ok = 1'b0;
      end
    end
  end

  assign hit = head_entry.tail_eq && enough && win_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (take) begin
      bytes_seen <= hit ? '0 : count_inc;
    end
  end

  // Window entries older than bytes_seen never take part in a compare,
  // so the window is neither reset nor cleared on a match.
  always_ff @(posedge clk) begin
    if (take && !hit) begin
      recent[0] <= head_entry.item.data_byte;
      for (int k = 1; k < WIN; k++) begin
        recent[k] <= recent[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.match_found <= hit;
      result.match_end   <= hit ? count_inc : '0;
      result.exhausted   <= !hit && head_entry.item.last_byte;
    end
  end

endmodule

// ===== rtl/stream_delimiter_search.sv =====
// Stream delimiter search: finds the first occurrence of a 1 to 16 byte
// separator in a byte stream fed one byte per request. Each byte yields one
// result: match_found when the separator ends at that byte, match_end as the
// count of bytes since the search start through the match (saturating at
// POSITION_LIMIT), and exhausted when a byte marked last passes with no
// match. After a match the count and window restart. The block sustains one
// byte per cycle while the result side does not stall; a request passes the
// front register, queue and result register before its result is presented,
// and the combinational window compare in the back stage allows that rate.
// Up to six requests are absorbed while the result side stalls before
// item_stall rises. Pattern registers are written through the cfg port, which
// never holds off, and must only be written while no request is in flight.
// Depends on sds_pkg and the sds_front, sds_queue and sds_back modules.
module stream_delimiter_search
  import sds_pkg::*;
#(
  parameter int MAX_PATTERN    = MAX_PATTERN_DEFAULT,
  parameter int POSITION_LIMIT = POSITION_LIMIT_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // Byte requests
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  // Per-byte results
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  // Register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [PLEN_W-1:0]     pattern_length;
  logic [PATTERN_W-1:0]  pattern;
  logic [LEN_W-1:0]      act_len;

  logic  push_valid;
  logic  push_full;
  qent_t push_entry;
  logic  head_valid;
  logic  head_ready;
  qent_t head_entry;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= PLEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_LOW: begin
          pattern_low <= cfg_data;
        end
        CFG_PATTERN_HIGH: begin
          pattern_high <= cfg_data;
        end
        CFG_PATTERN_LENGTH: begin
          pattern_length <= cfg_data[PLEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Separator byte 0 sits in the low byte of pattern_low.
  assign pattern = {pattern_high, pattern_low};

  // Length in use: zero means one, anything past MAX_PATTERN clamps.
  always_comb begin
    if (pattern_length == '0) begin
      act_len = LEN_W'(1);
    end else if (int'(pattern_length) > MAX_PATTERN) begin
      act_len = LEN_W'(MAX_PATTERN);
    end else begin
      act_len = LEN_W'(pattern_length);
    end
  end

  sds_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .pattern    (pattern),
    .act_len    (act_len),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_entry (push_entry)
  );

  sds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_entry (push_entry),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_entry  (head_entry)
  );

  sds_back #(
    .MAX_PATTERN    (MAX_PATTERN),
    .POSITION_LIMIT (POSITION_LIMIT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pattern      (pattern),
    .act_len      (act_len),
    .head_valid   (head_valid),
    .head_ready   (head_ready),
    .head_entry   (head_entry),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/sds_checker.sv =====
// Port-level checks on the delimiter search results, bound to the top level.
// Depends on sds_pkg and stream_delimiter_search_macros.svh.
`include "stream_delimiter_search_macros.svh"

module sds_checker
  import sds_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  `SDS_ASSERT_SAME(a_found_not_exhausted, result_valid && result.match_found, !result.exhausted, "match and exhaustion flagged together")
  `SDS_ASSERT_SAME(a_miss_zero_end, result_valid && !result.match_found, result.match_end == '0, "match_end nonzero without a match")
  `SDS_ASSERT_SAME(a_found_nonzero_end, result_valid && result.match_found, result.match_end != '0, "match reported at zero count")
  `SDS_ASSERT_NEXT(a_stalled_result_holds, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

endmodule

bind stream_delimiter_search sds_checker u_checker (.*);
